// ===== design/clhm_pkg.sv =====
// Shared constants, widths and the queued sample type for the CPU load history monitor.
package clhm_pkg;

  localparam int SAMPLES_PER_SEC = 10;
  localparam int HISTORY_DEPTH   = 600;
  localparam int WIN = (SAMPLES_PER_SEC < HISTORY_DEPTH) ? SAMPLES_PER_SEC : HISTORY_DEPTH;

  localparam int TICK_W = 18;
  localparam int PCT_W  = 16;
  localparam int HELD_W = 10;

  localparam longint unsigned BUSY_MAX = (64'd1 << TICK_W) - 64'd1;

  localparam int AW  = $clog2(HISTORY_DEPTH);
  localparam int AWX = AW + 1;
  localparam int CW  = $clog2(HISTORY_DEPTH + 1);

  localparam int SEC_W = $clog2(longint'(WIN) * BUSY_MAX + 64'd1);
  localparam int MIN_W = $clog2(longint'(HISTORY_DEPTH) * BUSY_MAX + 64'd1);

  localparam longint unsigned TICK_RATE    = 1193046;
  localparam longint unsigned SECS_PER_MIN = 60;
  localparam longint unsigned PCT_MAX      = 65535;
  localparam longint unsigned SCALE_NUM    = longint'(SAMPLES_PER_SEC) * 10000;
  localparam longint unsigned DIV_TICK     = TICK_RATE;
  localparam longint unsigned DIV_MIN      = TICK_RATE * SECS_PER_MIN;

  // Smallest operand whose scaled value reaches the saturation limit.
  localparam longint unsigned LIM_TICK = (PCT_MAX * DIV_TICK + SCALE_NUM - 1) / SCALE_NUM;
  localparam longint unsigned LIM_MIN  = (PCT_MAX * DIV_MIN + SCALE_NUM - 1) / SCALE_NUM;

  localparam int XW   = $clog2(LIM_MIN);
  localparam int SC_W = (MIN_W > XW + 1) ? MIN_W : XW + 1;

  // Reciprocals scaled by 2^XW, rounded down.
  localparam longint unsigned M_TICK = ((64'd1 << XW) * SCALE_NUM) / DIV_TICK;
  localparam longint unsigned M_MIN  = ((64'd1 << XW) * SCALE_NUM) / DIV_MIN;

  localparam int MW  = $clog2(M_TICK + 1);
  localparam int PW  = XW + MW;
  localparam int NW  = XW + $clog2(SCALE_NUM + 1);
  localparam int DW  = $clog2(DIV_MIN + 1);
  localparam int QDW = PCT_W + DW;
  localparam int RW  = (NW > QDW) ? NW : QDW;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam int CFG_IW = 1;
  localparam logic [CFG_IW-1:0] REG_INTERVAL  = 1'b0;
  localparam logic [CFG_IW-1:0] REG_THRESHOLD = 1'b1;

  localparam logic [TICK_W-1:0] INTERVAL_RST  = 18'd119304;
  localparam logic [TICK_W-1:0] THRESHOLD_RST = 18'd59652;

  typedef struct packed {
    logic [TICK_W-1:0] busy;
    logic [TICK_W-1:0] idle;
    logic [TICK_W-1:0] irq_ticks;
    logic              active;
    logic [AW-1:0]     pos;
    logic [AW-1:0]     leave;
    logic              sub_sec;
    logic              sub_min;
    logic [HELD_W-1:0] held;
  } sample_t;

endpackage

// ===== design/clhm_front.sv =====
// Front end: configuration registers, sample intake and per-sample classification.
module clhm_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [clhm_pkg::CFG_IW-1:0]     cfg_index,
  input  logic [clhm_pkg::TICK_W-1:0]     cfg_data,
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  logic [clhm_pkg::TICK_W-1:0]     busy_ticks,
  input  logic [clhm_pkg::TICK_W-1:0]     idle_ticks,
  input  logic                            q_full,
  output logic                            q_push,
  output clhm_pkg::sample_t               q_entry
);

  logic [clhm_pkg::TICK_W-1:0] interval_ticks;
  logic [clhm_pkg::TICK_W-1:0] busy_threshold;
  logic [clhm_pkg::AW-1:0]     pos;
  logic [clhm_pkg::CW-1:0]     fill;
  logic [clhm_pkg::AW-1:0]     pos_next;
  logic [clhm_pkg::CW-1:0]     fill_next;
  logic [clhm_pkg::TICK_W:0]   total;
  logic [clhm_pkg::TICK_W:0]   interval_x;
  logic [clhm_pkg::AWX-1:0]    pos_x;
  logic [clhm_pkg::AWX-1:0]    leave_x;

  assign sample_stall = q_full;
  assign q_push       = sample_valid && !q_full;

  always_comb begin
    total      = {1'b0, busy_ticks} + {1'b0, idle_ticks};
    interval_x = {1'b0, interval_ticks};
    pos_x      = {1'b0, pos};
    if (pos_x >= clhm_pkg::AWX'(clhm_pkg::WIN)) begin
      leave_x = pos_x - clhm_pkg::AWX'(clhm_pkg::WIN);
    end else begin
      leave_x = pos_x + clhm_pkg::AWX'(clhm_pkg::HISTORY_DEPTH - clhm_pkg::WIN);
    end
    if (pos == clhm_pkg::AW'(clhm_pkg::HISTORY_DEPTH - 1)) begin
      pos_next = '0;
    end else begin
      pos_next = pos + 1'b1;
    end
    if (fill == clhm_pkg::CW'(clhm_pkg::HISTORY_DEPTH)) begin
      fill_next = fill;
    end else begin
      fill_next = fill + 1'b1;
    end
    q_entry.busy   = busy_ticks;
    q_entry.idle   = idle_ticks;
    q_entry.active = total > {1'b0, busy_threshold};
    if (interval_x > total) begin
      q_entry.irq_ticks = clhm_pkg::TICK_W'(interval_x - total);
    end else begin
      q_entry.irq_ticks = '0;
    end
    q_entry.pos     = pos;
    q_entry.leave   = clhm_pkg::AW'(leave_x);
    q_entry.sub_sec = fill >= clhm_pkg::CW'(clhm_pkg::WIN);
    q_entry.sub_min = fill >= clhm_pkg::CW'(clhm_pkg::HISTORY_DEPTH);
    q_entry.held    = clhm_pkg::HELD_W'(fill_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_ticks <= clhm_pkg::INTERVAL_RST;
      busy_threshold <= clhm_pkg::THRESHOLD_RST;
      pos            <= '0;
      fill           <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          clhm_pkg::REG_INTERVAL:  interval_ticks <= cfg_data;
          clhm_pkg::REG_THRESHOLD: busy_threshold <= cfg_data;
          default: ;
        endcase
      end
      if (q_push) begin
        pos  <= pos_next;
        fill <= fill_next;
      end
    end
  end

endmodule

// ===== design/clhm_queue.sv =====
// Short first-in first-out queue of classified samples between front and back ends.
module clhm_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  clhm_pkg::sample_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output clhm_pkg::sample_t head
);

  clhm_pkg::sample_t           entries [clhm_pkg::QDEPTH];
  logic [clhm_pkg::QAW-1:0]    wr_ptr;
  logic [clhm_pkg::QAW-1:0]    rd_ptr;
  logic [clhm_pkg::QAW:0]      count;

  assign full       = count == (clhm_pkg::QAW + 1)'(clhm_pkg::QDEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/clhm_scale.sv =====
// Pipelined exact scaling of a tick count to hundredths of a percent, with saturation.
module clhm_scale (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         minute,
  input  logic [clhm_pkg::SC_W-1:0]    x,
  output logic [clhm_pkg::PCT_W-1:0]   pct
);

  logic [clhm_pkg::SC_W-1:0]  lim_sel;
  logic [clhm_pkg::MW-1:0]    m_sel;
  logic [clhm_pkg::DW-1:0]    d_sel;
  logic [clhm_pkg::XW-1:0]    xc;
  logic                       sat_b;
  logic [clhm_pkg::PW-1:0]    prod_b;
  logic [clhm_pkg::NW-1:0]    num_b;
  logic [clhm_pkg::PCT_W-1:0] q0;
  logic                       sat_c;
  logic [clhm_pkg::NW-1:0]    num_c;
  logic [clhm_pkg::PCT_W-1:0] q_c;
  logic [clhm_pkg::QDW-1:0]   qd_c;
  logic [clhm_pkg::RW-1:0]    rem;

  assign lim_sel = minute ? clhm_pkg::SC_W'(clhm_pkg::LIM_MIN) : clhm_pkg::SC_W'(clhm_pkg::LIM_TICK);
  assign m_sel   = minute ? clhm_pkg::MW'(clhm_pkg::M_MIN) : clhm_pkg::MW'(clhm_pkg::M_TICK);
  assign d_sel   = minute ? clhm_pkg::DW'(clhm_pkg::DIV_MIN) : clhm_pkg::DW'(clhm_pkg::DIV_TICK);
  assign xc      = x[clhm_pkg::XW-1:0];
  assign q0      = clhm_pkg::PCT_W'(prod_b >> clhm_pkg::XW);

  // The reciprocal estimate is at most one below the true quotient.
  assign rem = clhm_pkg::RW'(num_c) - clhm_pkg::RW'(qd_c);

  always_comb begin
    if (sat_c) begin
      pct = clhm_pkg::PCT_W'(clhm_pkg::PCT_MAX);
    end else if (rem >= clhm_pkg::RW'(d_sel)) begin
      pct = q_c + 1'b1;
    end else begin
      pct = q_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat_b  <= x >= lim_sel;
      prod_b <= clhm_pkg::PW'(xc) * clhm_pkg::PW'(m_sel);
      num_b  <= clhm_pkg::NW'(xc) * clhm_pkg::NW'(clhm_pkg::SCALE_NUM);
      sat_c  <= sat_b;
      num_c  <= num_b;
      q_c    <= q0;
      qd_c   <= clhm_pkg::QDW'(q0) * clhm_pkg::QDW'(d_sel);
    end
  end

endmodule

// ===== design/clhm_back.sv =====
// Back end: history memory, running sums, load scaling and the result register.
module clhm_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  clhm_pkg::sample_t             q_head,
  output logic                          q_pop,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          active,
  output logic [clhm_pkg::PCT_W-1:0]    busy_pct,
  output logic [clhm_pkg::PCT_W-1:0]    idle_pct,
  output logic [clhm_pkg::PCT_W-1:0]    irq_pct,
  output logic [clhm_pkg::PCT_W-1:0]    second_pct,
  output logic [clhm_pkg::PCT_W-1:0]    minute_pct,
  output logic [clhm_pkg::HELD_W-1:0]   samples_held
);

  typedef enum logic {ST_READ, ST_UPDATE} state_t;

  state_t                       st;
  logic                         adv;
  clhm_pkg::sample_t            cur;
  logic [clhm_pkg::TICK_W-1:0]  hist [clhm_pkg::HISTORY_DEPTH];
  logic [clhm_pkg::TICK_W-1:0]  rd_leave;
  logic [clhm_pkg::TICK_W-1:0]  rd_old;
  logic [clhm_pkg::SEC_W-1:0]   second_sum;
  logic [clhm_pkg::MIN_W-1:0]   minute_sum;
  logic [clhm_pkg::SEC_W-1:0]   second_sum_next;
  logic [clhm_pkg::MIN_W-1:0]   minute_sum_next;

  logic                         v1, v2, v3;
  logic                         a1, a2, a3;
  logic [clhm_pkg::HELD_W-1:0]  h1, h2, h3;
  logic [clhm_pkg::TICK_W-1:0]  s1_busy, s1_idle, s1_irq;
  logic [clhm_pkg::SEC_W-1:0]   s1_sec;
  logic [clhm_pkg::MIN_W-1:0]   s1_min;
  logic [clhm_pkg::PCT_W-1:0]   busy_sc, idle_sc, irq_sc, sec_sc, min_sc;

  assign adv   = !result_valid || !result_stall;
  assign q_pop = adv && (st == ST_READ) && q_valid;

  always_comb begin
    second_sum_next = second_sum
                    - (cur.sub_sec ? clhm_pkg::SEC_W'(rd_leave) : '0)
                    + clhm_pkg::SEC_W'(cur.busy);
    minute_sum_next = minute_sum
                    - (cur.sub_min ? clhm_pkg::MIN_W'(rd_old) : '0)
                    + clhm_pkg::MIN_W'(cur.busy);
  end

  // Both outgoing entries are read together on a pop; the new sample is written in the update state.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_leave <= hist[q_head.leave];
      rd_old   <= hist[q_head.pos];
    end
    if (adv && st == ST_UPDATE) begin
      hist[cur.pos] <= cur.busy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= ST_READ;
      second_sum   <= '0;
      minute_sum   <= '0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      v1           <= st == ST_UPDATE;
      v2           <= v1;
      v3           <= v2;
      result_valid <= v3;
      case (st)
        ST_READ: begin
          if (q_valid) begin
            st <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          st         <= ST_READ;
          second_sum <= second_sum_next;
          minute_sum <= minute_sum_next;
        end
        default: st <= ST_READ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    if (adv) begin
      if (st == ST_UPDATE) begin
        a1      <= cur.active;
        h1      <= cur.held;
        s1_busy <= cur.busy;
        s1_idle <= cur.idle;
        s1_irq  <= cur.irq_ticks;
        s1_sec  <= second_sum_next;
        s1_min  <= minute_sum_next;
      end
      a2           <= a1;
      h2           <= h1;
      a3           <= a2;
      h3           <= h2;
      active       <= a3;
      samples_held <= h3;
      busy_pct     <= busy_sc;
      idle_pct     <= idle_sc;
      irq_pct      <= irq_sc;
      second_pct   <= sec_sc;
      minute_pct   <= min_sc;
    end
  end

  clhm_scale u_busy (
    .clk(clk), .en(adv), .minute(1'b0),
    .x(clhm_pkg::SC_W'(s1_busy)), .pct(busy_sc)
  );

  clhm_scale u_idle (
    .clk(clk), .en(adv), .minute(1'b0),
    .x(clhm_pkg::SC_W'(s1_idle)), .pct(idle_sc)
  );

  clhm_scale u_irq (
    .clk(clk), .en(adv), .minute(1'b0),
    .x(clhm_pkg::SC_W'(s1_irq)), .pct(irq_sc)
  );

  clhm_scale u_second (
    .clk(clk), .en(adv), .minute(1'b0),
    .x(clhm_pkg::SC_W'(s1_sec)), .pct(sec_sc)
  );

  clhm_scale u_minute (
    .clk(clk), .en(adv), .minute(1'b1),
    .x(clhm_pkg::SC_W'(s1_min)), .pct(min_sc)
  );

endmodule

// ===== design/cpu_load_history_monitor_top.sv =====
// Top level of the CPU load history monitor.
// The block takes one sample transfer of busy and idle tick counts and returns one result
// transfer per sample, in order. Each sample passes a read state, which fetches the two
// outgoing history entries from the dual-read history memory, and an update state, which
// updates the running sums and writes the new entry; the back end takes the next sample
// only in the read state. A result then passes the scaling pipeline and result register.
// A four-entry queue lets further samples be taken while a result is held back by stall.
// No clearing pass is needed after reset, and configuration writes take effect at once.
module cpu_load_history_monitor_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [clhm_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [clhm_pkg::TICK_W-1:0]   cfg_data,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic [clhm_pkg::TICK_W-1:0]   busy_ticks,
  input  logic [clhm_pkg::TICK_W-1:0]   idle_ticks,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          active,
  output logic [clhm_pkg::PCT_W-1:0]    busy_pct,
  output logic [clhm_pkg::PCT_W-1:0]    idle_pct,
  output logic [clhm_pkg::PCT_W-1:0]    irq_pct,
  output logic [clhm_pkg::PCT_W-1:0]    second_pct,
  output logic [clhm_pkg::PCT_W-1:0]    minute_pct,
  output logic [clhm_pkg::HELD_W-1:0]   samples_held
);

  logic              q_full;
  logic              q_push;
  clhm_pkg::sample_t q_entry;
  logic              q_pop;
  logic              q_valid;
  clhm_pkg::sample_t q_head;

  clhm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .busy_ticks   (busy_ticks),
    .idle_ticks   (idle_ticks),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  clhm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  clhm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .active       (active),
    .busy_pct     (busy_pct),
    .idle_pct     (idle_pct),
    .irq_pct      (irq_pct),
    .second_pct   (second_pct),
    .minute_pct   (minute_pct),
    .samples_held (samples_held)
  );

endmodule

// ===== design/clhm_checker.sv =====
// Port-level assertion checker for the CPU load history monitor, bound to the top level.
module clhm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          sample_valid,
  input logic                          sample_stall,
  input logic                          result_valid,
  input logic                          result_stall,
  input logic                          active,
  input logic [clhm_pkg::PCT_W-1:0]    busy_pct,
  input logic [clhm_pkg::PCT_W-1:0]    idle_pct,
  input logic [clhm_pkg::PCT_W-1:0]    irq_pct,
  input logic [clhm_pkg::PCT_W-1:0]    second_pct,
  input logic [clhm_pkg::PCT_W-1:0]    minute_pct,
  input logic [clhm_pkg::HELD_W-1:0]   samples_held
);

  logic [15:0] pending;
  logic        in_xfer;
  logic        out_xfer;

  assign in_xfer  = sample_valid && !sample_stall;
  assign out_xfer = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({in_xfer, out_xfer})
        2'b10:   pending <= pending + 1'b1;
        2'b01:   pending <= pending - 1'b1;
        default: pending <= pending;
      endcase
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid just after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pending != 16'd0)
    else $error("result offered without an outstanding sample");

  a_held_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (clhm_pkg::HISTORY_DEPTH > 1023) ||
      (samples_held != 10'd0 && 32'(samples_held) <= clhm_pkg::HISTORY_DEPTH))
    else $error("sample count outside the history depth");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(active) && $stable(busy_pct) && $stable(idle_pct) &&
      $stable(irq_pct) && $stable(second_pct) && $stable(minute_pct) &&
      $stable(samples_held))
    else $error("stalled result changed");

endmodule

bind cpu_load_history_monitor_top clhm_checker u_clhm_checker (.*);
